@@ rtl/moving_average_with_error_assert.svh @@
// assertion macros shared by the moving average rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef MOVING_AVERAGE_WITH_ERROR_ASSERT_SVH
`define MOVING_AVERAGE_WITH_ERROR_ASSERT_SVH

// same-cycle implication
`define MAWE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MAWE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mawe_pkg.sv @@
// shared constants, width helpers and back end state type for the moving average block
// no dependencies
package mawe_pkg;

    localparam int MAX_WINDOW_DEF     = 256;
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int RUN_COUNT_BITS_DEF = 24;
    localparam int CFG_BITS           = 9;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(4);

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_AVG_DIV,
        BK_ERR,
        BK_MEAN_DIV,
        BK_OUT
    } bk_state_t;

    function automatic int addr_bits(input int max_window);
        return $clog2(max_window);
    endfunction

    function automatic int cnt_bits(input int max_window);
        return $clog2(max_window + 1);
    endfunction

    function automatic int sum_bits(input int max_window, input int sample_bits);
        return sample_bits + $clog2(max_window) + 1;
    endfunction

    function automatic int acc_bits(input int sample_bits, input int run_count_bits);
        return sample_bits + 1 + run_count_bits;
    endfunction

    function automatic int entry_bits(input int max_window, input int sample_bits);
        return sum_bits(max_window, sample_bits) + cnt_bits(max_window) + sample_bits + 1;
    endfunction

    function automatic int div_n_bits(input int max_window, input int sample_bits,
                                      input int run_count_bits);
        int s;
        int a;
        s = sum_bits(max_window, sample_bits);
        a = acc_bits(sample_bits, run_count_bits);
        return (s > a) ? s : a;
    endfunction

    function automatic int div_d_bits(input int max_window, input int run_count_bits);
        int c;
        c = cnt_bits(max_window);
        return (c > run_count_bits) ? c : run_count_bits;
    endfunction

endpackage

@@ rtl/mawe_if.sv @@
// valid/ready channel interfaces: sample input, result output, window length config
// depends on mawe_pkg
interface mawe_in_if #(
    parameter int SAMPLE_BITS = mawe_pkg::SAMPLE_BITS_DEF
);
    import mawe_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] reading;
    logic signed [SAMPLE_BITS-1:0] reference;
    logic                          last;

    modport source (output valid, output reading, output reference, output last, input ready);
    modport sink   (input valid, input reading, input reference, input last, output ready);
endinterface

interface mawe_out_if #(
    parameter int SAMPLE_BITS = mawe_pkg::SAMPLE_BITS_DEF
);
    import mawe_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic signed [SAMPLE_BITS:0]   error;
    logic        [SAMPLE_BITS-1:0] mean_abs_error;
    logic                          run_done;

    modport source (output valid, output average, output error, output mean_abs_error,
                    output run_done, input ready);
    modport sink   (input valid, input average, input error, input mean_abs_error,
                    input run_done, output ready);
endinterface

interface mawe_cfg_if;
    import mawe_pkg::*;

    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/moving_average_with_error.sv @@
// top level of the moving average block with error statistics
// depends on mawe_pkg, mawe_if, mawe_ram, mawe_queue, mawe_div, mawe_front, mawe_back
//
// sample channel: one word per sample, a Q3.12 reading, its clean reference and a
// last flag that closes the run. result channel: one word per sample with the
// moving average, reference minus average, and on the last word the mean absolute
// error of the run (zero otherwise). cfg channel: writes the window length, is
// always ready, and restarts the run; write it only while no sample is in flight.
// the front end takes a sample a cycle while its queue has room and pushes the
// window sum into the queue in the cycle after. the back end handles one queued word
// at a time on a shared bit-serial divider of DN bits (41 with default parameters):
// it pops a word and divides the sum by the count, forms the error and adds its
// magnitude to the run's error sum, on the last word of a run divides that sum by the
// run length for the mean, and pops no new word until the result word is taken.
// reset sets the window length to 4 and empties the run, queue and pipeline.
// when the receiver holds off ready, the finished word stays in the output
// register, the back end waits, and the front end keeps taking samples until the
// queue is full, then drops its own ready.
module moving_average_with_error #(
    parameter int MAX_WINDOW     = mawe_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS    = mawe_pkg::SAMPLE_BITS_DEF,
    parameter int RUN_COUNT_BITS = mawe_pkg::RUN_COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mawe_in_if.sink     sample,
    mawe_out_if.source  result,
    mawe_cfg_if.sink    cfg
);
    import mawe_pkg::*;

    localparam int AW = addr_bits(MAX_WINDOW);
    localparam int EW = entry_bits(MAX_WINDOW, SAMPLE_BITS);
    localparam int DN = div_n_bits(MAX_WINDOW, SAMPLE_BITS, RUN_COUNT_BITS);
    localparam int DD = div_d_bits(MAX_WINDOW, RUN_COUNT_BITS);
    localparam int QC = $clog2(QUEUE_DEPTH + 1);

    logic                   run_clear;
    logic                   push;
    logic [EW-1:0]          push_data;
    logic                   pop;
    logic [EW-1:0]          pop_data;
    logic [QC-1:0]          q_count;
    logic                   q_empty;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   div_start;
    logic [DN-1:0]          div_dividend;
    logic [DD-1:0]          div_divisor;
    logic                   div_busy;
    logic                   div_done;
    logic [DN-1:0]          div_quotient;

    assign run_clear = cfg.valid && cfg.ready;

    mawe_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .cfg       (cfg),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    mawe_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mawe_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .count     (q_count),
        .empty     (q_empty)
    );

    mawe_div #(
        .N (DN),
        .D (DD)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    mawe_back #(
        .MAX_WINDOW     (MAX_WINDOW),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .RUN_COUNT_BITS (RUN_COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .run_clear    (run_clear),
        .q_empty      (q_empty),
        .pop          (pop),
        .pop_data     (pop_data),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_busy     (div_busy),
        .div_done     (div_done),
        .div_quotient (div_quotient),
        .result       (result)
    );
endmodule

@@ rtl/mawe_ram.sv @@
// generic single write port, single read port ram with registered read-first output
// no dependencies
module mawe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end
endmodule

@@ rtl/mawe_queue.sv @@
// small register queue between the front end and the back end
// no dependencies
module mawe_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic                       empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slot[rd_ptr_reg];
    assign count    = count_reg;
    assign empty    = (count_reg == '0);
endmodule

@@ rtl/mawe_div.sv @@
// shared restoring divider, one quotient bit per cycle
// no dependencies
module mawe_div #(
    parameter int N = 41,
    parameter int D = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         busy,
    output logic         done,
    output logic [N-1:0] quotient
);
    localparam int CW = $clog2(N + 1);

    logic [D-1:0]  rem_reg, rem_next;
    logic [N-1:0]  quo_reg, quo_next;
    logic [D-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [D:0]    trial;
    logic [D:0]    diff;
    logic          ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[N-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = (trial >= {1'b0, dsr_reg});

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CW'(N);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[D-1:0] : trial[D-1:0];
            quo_next = {quo_reg[N-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

@@ rtl/mawe_front.sv @@
// front end: takes sample words, keeps the window ring and running sum, queues sum and count
// depends on mawe_pkg, mawe_if, moving_average_with_error_assert.svh
`include "moving_average_with_error_assert.svh"

module mawe_front #(
    parameter int MAX_WINDOW  = mawe_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = mawe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    mawe_in_if.sink                                                sample,
    mawe_cfg_if.sink                                               cfg,
    input  logic [$clog2(mawe_pkg::QUEUE_DEPTH+1)-1:0]             q_count,
    output logic                                                   push,
    output logic [mawe_pkg::entry_bits(MAX_WINDOW,SAMPLE_BITS)-1:0] push_data,
    output logic                                                   ram_we,
    output logic [$clog2(MAX_WINDOW)-1:0]                          ram_waddr,
    output logic [SAMPLE_BITS-1:0]                                 ram_wdata,
    output logic                                                   ram_re,
    output logic [$clog2(MAX_WINDOW)-1:0]                          ram_raddr,
    input  logic [SAMPLE_BITS-1:0]                                 ram_rdata
);
    import mawe_pkg::*;

    localparam int AW  = addr_bits(MAX_WINDOW);
    localparam int AW1 = AW + 1;
    localparam int CW  = cnt_bits(MAX_WINDOW);
    localparam int SW  = sum_bits(MAX_WINDOW, SAMPLE_BITS);
    localparam int LW  = (CFG_BITS > CW) ? CFG_BITS : CW;
    localparam int QW  = $clog2(QUEUE_DEPTH + 1) + 1;

    logic [CFG_BITS-1:0]           wl_reg, wl_next;
    logic [CW-1:0]                 filled_reg, filled_next;
    logic [AW-1:0]                 wp_reg, wp_next;
    logic signed [SW-1:0]          sum_reg, sum_next;
    logic                          s_valid_reg, s_valid_next;
    logic                          s_sub_reg;
    logic [CW-1:0]                 s_count_reg;
    logic signed [SAMPLE_BITS-1:0] s_x_reg;
    logic signed [SAMPLE_BITS-1:0] s_ref_reg;
    logic                          s_last_reg;

    logic                          fire;
    logic [LW-1:0]                 wl_ext;
    logic [CW-1:0]                 w_eff;
    logic                          full;
    logic [AW1-1:0]                wp_ext;
    logic [AW1-1:0]                w_ext;
    logic [AW1-1:0]                old_ext;
    logic [QW-1:0]                 room;
    logic signed [SW-1:0]          sum_new;

    always_comb
    begin
        // effective window, clamped to 1..MAX_WINDOW
        wl_ext = LW'(wl_reg);
        if (wl_ext == '0)
        begin
            w_eff = CW'(1);
        end
        else if (wl_ext > LW'(MAX_WINDOW))
        begin
            w_eff = CW'(MAX_WINDOW);
        end
        else
        begin
            w_eff = CW'(wl_ext);
        end
        full = (filled_reg >= w_eff);

        // ring slot of the sample leaving the window
        wp_ext  = {1'b0, wp_reg};
        w_ext   = AW1'(w_eff);
        old_ext = (wp_ext >= w_ext) ? (wp_ext - w_ext)
                                    : (wp_ext + AW1'(MAX_WINDOW) - w_ext);

        room         = QW'(q_count) + QW'(s_valid_reg);
        sample.ready = (room < QW'(QUEUE_DEPTH));
        fire         = sample.valid && sample.ready;
        cfg.ready    = 1'b1;

        ram_we    = fire;
        ram_waddr = wp_reg;
        ram_wdata = sample.reading;
        ram_re    = fire;
        ram_raddr = old_ext[AW-1:0];

        sum_new = sum_reg + SW'(s_x_reg)
                - (s_sub_reg ? SW'($signed(ram_rdata)) : SW'(0));

        push      = s_valid_reg;
        push_data = {s_last_reg, s_ref_reg, s_count_reg, sum_new};

        wl_next      = wl_reg;
        filled_next  = filled_reg;
        wp_next      = wp_reg;
        sum_next     = sum_reg;
        s_valid_next = fire;

        if (fire)
        begin
            if (sample.last)
            begin
                filled_next = '0;
                wp_next     = '0;
            end
            else
            begin
                filled_next = full ? filled_reg : (filled_reg + CW'(1));
                wp_next     = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : (wp_reg + AW'(1));
            end
        end

        if (s_valid_reg)
        begin
            sum_next = s_last_reg ? SW'(0) : sum_new;
        end

        if (cfg.valid)
        begin
            wl_next     = cfg.data;
            filled_next = '0;
            wp_next     = '0;
            sum_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg      <= WINDOW_RESET;
            filled_reg  <= '0;
            wp_reg      <= '0;
            sum_reg     <= '0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            wl_reg      <= wl_next;
            filled_reg  <= filled_next;
            wp_reg      <= wp_next;
            sum_reg     <= sum_next;
            s_valid_reg <= s_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s_sub_reg   <= full;
            s_count_reg <= full ? w_eff : (filled_reg + CW'(1));
            s_x_reg     <= sample.reading;
            s_ref_reg   <= sample.reference;
            s_last_reg  <= sample.last;
        end
    end

    `MAWE_ASSERT_IMP(a_queue_room, push, QW'(q_count) < QW'(QUEUE_DEPTH), "queue overflow")
    `MAWE_ASSERT_NXT(a_last_clears, fire && sample.last, (filled_reg == '0) && (wp_reg == '0), "run not cleared after last word")
endmodule

@@ rtl/mawe_back.sv @@
// back end: divides sum by count, forms error, accumulates abs error, reports mean on last
// depends on mawe_pkg, mawe_if, moving_average_with_error_assert.svh
`include "moving_average_with_error_assert.svh"

module mawe_back #(
    parameter int MAX_WINDOW     = mawe_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS    = mawe_pkg::SAMPLE_BITS_DEF,
    parameter int RUN_COUNT_BITS = mawe_pkg::RUN_COUNT_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic run_clear,
    input  logic q_empty,
    output logic pop,
    input  logic [mawe_pkg::entry_bits(MAX_WINDOW,SAMPLE_BITS)-1:0] pop_data,
    output logic div_start,
    output logic [mawe_pkg::div_n_bits(MAX_WINDOW,SAMPLE_BITS,RUN_COUNT_BITS)-1:0] div_dividend,
    output logic [mawe_pkg::div_d_bits(MAX_WINDOW,RUN_COUNT_BITS)-1:0] div_divisor,
    input  logic div_busy,
    input  logic div_done,
    input  logic [mawe_pkg::div_n_bits(MAX_WINDOW,SAMPLE_BITS,RUN_COUNT_BITS)-1:0] div_quotient,
    mawe_out_if.source result
);
    import mawe_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int CW  = cnt_bits(MAX_WINDOW);
    localparam int SW  = sum_bits(MAX_WINDOW, SAMPLE_BITS);
    localparam int EW  = entry_bits(MAX_WINDOW, SAMPLE_BITS);
    localparam int ACW = acc_bits(SAMPLE_BITS, RUN_COUNT_BITS);
    localparam int DN  = div_n_bits(MAX_WINDOW, SAMPLE_BITS, RUN_COUNT_BITS);
    localparam int DD  = div_d_bits(MAX_WINDOW, RUN_COUNT_BITS);

    bk_state_t                 state_reg, state_next;
    logic                      sign_reg, sign_next;
    logic signed [SB-1:0]      ref_reg, ref_next;
    logic                      last_reg, last_next;
    logic signed [SB-1:0]      avg_reg, avg_next;
    logic signed [SB:0]        err_reg, err_next;
    logic [SB-1:0]             mean_reg, mean_next;
    logic [ACW-1:0]            acc_reg, acc_next;
    logic [RUN_COUNT_BITS-1:0] rc_reg, rc_next;

    logic signed [SW-1:0]      q_sum;
    logic [SW-1:0]             q_sum_mag;
    logic [CW-1:0]             q_cnt;
    logic signed [SB-1:0]      q_ref;
    logic                      q_last;
    logic signed [SB-1:0]      quo_lo;
    logic signed [SB:0]        err_w;
    logic [SB:0]               err_mag;
    logic                      sat;
    logic [ACW-1:0]            acc_upd;
    logic [RUN_COUNT_BITS-1:0] rc_upd;

    always_comb
    begin
        q_sum     = pop_data[SW-1:0];
        q_cnt     = pop_data[SW+CW-1:SW];
        q_ref     = pop_data[SW+CW+SB-1:SW+CW];
        q_last    = pop_data[EW-1];
        q_sum_mag = q_sum[SW-1] ? SW'(-q_sum) : SW'(q_sum);
        quo_lo    = div_quotient[SB-1:0];

        err_w   = (SB+1)'(ref_reg) - (SB+1)'(avg_reg);
        err_mag = err_w[SB] ? (SB+1)'(-err_w) : (SB+1)'(err_w);
        sat     = (rc_reg == '1);
        acc_upd = sat ? acc_reg : (acc_reg + ACW'(err_mag));
        rc_upd  = sat ? rc_reg : (rc_reg + RUN_COUNT_BITS'(1));

        state_next   = state_reg;
        sign_next    = sign_reg;
        ref_next     = ref_reg;
        last_next    = last_reg;
        avg_next     = avg_reg;
        err_next     = err_reg;
        mean_next    = mean_reg;
        acc_next     = acc_reg;
        rc_next      = rc_reg;
        pop          = 1'b0;
        div_start    = 1'b0;
        div_dividend = DN'(q_sum_mag);
        div_divisor  = DD'(q_cnt);

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    div_start  = 1'b1;
                    sign_next  = q_sum[SW-1];
                    ref_next   = q_ref;
                    last_next  = q_last;
                    state_next = BK_AVG_DIV;
                end
            end
            BK_AVG_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = sign_reg ? -quo_lo : quo_lo;
                    state_next = BK_ERR;
                end
            end
            BK_ERR:
            begin
                err_next = err_w;
                acc_next = acc_upd;
                rc_next  = rc_upd;
                if (last_reg)
                begin
                    div_start    = 1'b1;
                    div_dividend = DN'(acc_upd);
                    div_divisor  = DD'(rc_upd);
                    state_next   = BK_MEAN_DIV;
                end
                else
                begin
                    mean_next  = '0;
                    state_next = BK_OUT;
                end
            end
            BK_MEAN_DIV:
            begin
                if (div_done)
                begin
                    mean_next  = div_quotient[SB-1:0];
                    acc_next   = '0;
                    rc_next    = '0;
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (result.ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (run_clear)
        begin
            acc_next = '0;
            rc_next  = '0;
        end

        result.valid          = (state_reg == BK_OUT);
        result.average        = avg_reg;
        result.error          = err_reg;
        result.mean_abs_error = mean_reg;
        result.run_done       = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            acc_reg   <= '0;
            rc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            rc_reg    <= rc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg <= sign_next;
        ref_reg  <= ref_next;
        last_reg <= last_next;
        avg_reg  <= avg_next;
        err_reg  <= err_next;
        mean_reg <= mean_next;
    end

    `MAWE_ASSERT_IMP(a_div_free, div_start, !div_busy, "divider started while busy")
    `MAWE_ASSERT_IMP(a_mean_zero, result.valid && !result.run_done, result.mean_abs_error == '0, "mean set on a word that ends no run")
    `MAWE_ASSERT_IMP(a_run_cleared, (state_reg == BK_OUT) && last_reg, (acc_reg == '0) && (rc_reg == '0), "error sum not cleared at end of run")
endmodule

@@ dv/tb_moving_average_with_error.sv @@
// self-checking testbench for the moving average block with error statistics
// drives sample words and window length writes, predicts every result word in place
// depends on mawe_pkg, mawe_if and the moving_average_with_error rtl
module tb_moving_average_with_error;
    import mawe_pkg::*;

    localparam int SB         = SAMPLE_BITS_DEF;
    localparam int RING_DEPTH = MAX_WINDOW_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN      = 100;
    localparam logic signed [SB-1:0] CORNERS [5] = '{16'sh7fff, 16'sh8000, 16'sh0000,
                                                     16'sh0001, 16'shffff};

    typedef struct packed {
        logic signed [SB-1:0] reading;
        logic signed [SB-1:0] reference;
        logic                 last;
    } sample_word_t;

    typedef struct packed {
        logic signed [SB-1:0] average;
        logic signed [SB:0]   error;
        logic        [SB-1:0] mean_abs_error;
        logic                 run_done;
    } average_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mawe_in_if  sample_ch ();
    mawe_out_if result_ch ();
    mawe_cfg_if cfg_ch ();

    moving_average_with_error dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sample_word_t  queued_samples [$];
    average_word_t predicted_averages [$];
    sample_word_t  next_sample;
    average_word_t want;

    // predictor state
    logic [CFG_BITS-1:0]       window_reg = WINDOW_RESET;
    logic signed [SB-1:0]      ring [RING_DEPTH];
    logic signed [24:0]        window_total = '0;
    logic [7:0]                wr_ptr = '0;
    logic [8:0]                fill_cnt = '0;
    logic [40:0]               abs_err_total = '0;
    logic [23:0]               run_len = '0;

    logic in_fire = 1'b0;
    bit   steady = 1'b0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   idle_cycles = 0;
    int   mismatches = 0;
    int   samples_in = 0;
    int   results_seen = 0;
    int   closed_runs = 0;
    int   window_writes = 0;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 60);
    endfunction

    function automatic void clear_run();
        window_total  = '0;
        wr_ptr        = '0;
        fill_cnt      = '0;
        abs_err_total = '0;
        run_len       = '0;
    endfunction

    function automatic average_word_t advance_average(input sample_word_t s);
        logic [8:0]     span;
        logic [7:0]     oldest;
        longint         count;
        longint         avg_l;
        longint         err_l;
        logic [SB:0]    mag;
        average_word_t  res;
        span = (window_reg == 0) ? 9'd1 :
               (window_reg > RING_DEPTH) ? 9'(RING_DEPTH) : window_reg;
        if (fill_cnt < span)
        begin
            window_total = window_total + $signed(s.reading);
            fill_cnt     = fill_cnt + 1'b1;
            count        = longint'(fill_cnt);
        end
        else
        begin
            oldest       = wr_ptr - span[7:0];
            window_total = window_total + $signed(s.reading) - ring[oldest];
            count        = longint'(span);
        end
        ring[wr_ptr] = $signed(s.reading);
        wr_ptr       = wr_ptr + 1'b1;

        avg_l = longint'(window_total) / count;
        err_l = longint'($signed(s.reference)) - avg_l;
        mag   = (err_l < 0) ? (SB+1)'(-err_l) : (SB+1)'(err_l);
        if (run_len != '1)
        begin
            run_len       = run_len + 1'b1;
            abs_err_total = abs_err_total + mag;
        end

        res.average        = avg_l[SB-1:0];
        res.error          = err_l[SB:0];
        res.mean_abs_error = '0;
        res.run_done       = s.last;
        if (s.last)
        begin
            if (run_len != 0)
                res.mean_abs_error = SB'(abs_err_total / run_len);
            clear_run();
        end
        return res;
    endfunction

    task automatic check_field(input string field, input longint exp_val, input longint act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
            mismatches++;
        end
    endtask

    // sample driver
    always @(negedge clk)
    begin
        if (!rst_n)
            sample_ch.valid <= 1'b0;
        else if (!sample_ch.valid || in_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                sample_ch.valid <= 1'b0;
            end
            else if (queued_samples.size() > 0)
            begin
                next_sample = queued_samples.pop_front();
                sample_ch.reading   <= next_sample.reading;
                sample_ch.reference <= next_sample.reference;
                sample_ch.last      <= next_sample.last;
                sample_ch.valid     <= 1'b1;
                send_gap = pick_gap();
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    // result ready driver
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap();
            result_ch.ready <= 1'b1;
        end
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        in_fire <= rst_n && sample_ch.valid && sample_ch.ready;
        if ($urandom_range(0, 299) == 0)
            steady = !steady;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                window_reg = cfg_ch.data;
                clear_run();
                window_writes++;
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                predicted_averages.push_back(advance_average({sample_ch.reading,
                                                              sample_ch.reference,
                                                              sample_ch.last}));
                samples_in++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (predicted_averages.size() == 0)
                begin
                    $error("result word with no prediction pending");
                    mismatches++;
                end
                else
                begin
                    want = predicted_averages.pop_front();
                    check_field("average", $signed(want.average), result_ch.average);
                    check_field("error", $signed(want.error), result_ch.error);
                    check_field("mean_abs_error", want.mean_abs_error,
                                result_ch.mean_abs_error);
                    check_field("run_done", want.run_done, result_ch.run_done);
                    if (want.run_done)
                        closed_runs++;
                end
            end
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no handshake in %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, predicted_averages.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic queue_sample(input logic signed [SB-1:0] reading,
                                input logic signed [SB-1:0] reference, input logic last);
        queued_samples.push_back({reading, reference, last});
    endtask

    task automatic add_run(input int len, input bit close);
        int                   style;
        int                   j;
        logic signed [SB-1:0] level;
        sample_word_t         s;
        style = $urandom_range(0, 9);
        level = SB'($urandom);
        for (j = 0; j < len; j++)
        begin
            if (style < 5)
            begin
                // smooth signal plus noise
                level       = level + SB'($urandom_range(0, 400) - 200);
                s.reference = level;
                s.reading   = level + SB'($urandom_range(0, 2000) - 1000);
            end
            else if (style < 8)
            begin
                s.reading   = SB'($urandom);
                s.reference = SB'($urandom);
            end
            else
            begin
                s.reading   = CORNERS[$urandom_range(0, 4)];
                s.reference = CORNERS[$urandom_range(0, 4)];
            end
            s.last = close && (j == len - 1);
            queued_samples.push_back(s);
        end
    endtask

    task automatic random_phase(input int items, input int max_run);
        int added;
        int len;
        added = 0;
        while (added < items)
        begin
            len = $urandom_range(1, max_run);
            add_run(len, $urandom_range(0, 9) != 0);
            added += len;
        end
    endtask

    task automatic wait_idle();
        while (queued_samples.size() != 0 || sample_ch.valid || predicted_averages.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_BITS-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        sample_ch.valid     = 1'b0;
        sample_ch.reading   = '0;
        sample_ch.reference = '0;
        sample_ch.last      = 1'b0;
        result_ch.ready     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // window of 4 from reset: extremes, largest errors of both signs, truncation
        repeat (5) queue_sample(16'sh7fff, 16'sh8000, 1'b0);
        repeat (4) queue_sample(16'sh8000, 16'sh7fff, 1'b0);
        queue_sample(16'sh8000, 16'sh7fff, 1'b1);
        queue_sample(16'sh0000, 16'sh0000, 1'b1);
        queue_sample(16'sh0001, 16'shffff, 1'b0);
        queue_sample(16'shffff, 16'sh0001, 1'b0);
        queue_sample(16'shfffd, 16'sh0000, 1'b0);
        queue_sample(16'sh0005, 16'sh0005, 1'b1);
        random_phase(40, 12);

        write_window(9'd1);
        queue_sample(16'sh0064, 16'shff9c, 1'b0);
        queue_sample(16'shfff9, 16'sh0000, 1'b0);
        queue_sample(16'sh7fff, 16'sh8000, 1'b1);
        queue_sample(16'sh8000, 16'sh7fff, 1'b1);
        random_phase(30, 6);

        // zero acts as one
        write_window(9'd0);
        random_phase(30, 6);

        write_window(9'd256);
        add_run(270, 1'b1);
        add_run(10, 1'b0);

        // above the maximum acts as the maximum
        write_window(9'h1ff);
        add_run(262, 1'b1);

        write_window(9'd2);
        random_phase(30, 8);

        write_window(9'd3);
        random_phase(30, 10);
        add_run(5, 1'b0);

        repeat (3)
        begin
            write_window(CFG_BITS'($urandom_range(0, 511)));
            random_phase(20, 40);
        end

        write_window(WINDOW_RESET);
        random_phase(30, 12);

        wait_idle();
        repeat (DRAIN) @(posedge clk);
        if (predicted_averages.size() != 0)
        begin
            $error("%0d predicted results never arrived", predicted_averages.size());
            mismatches++;
        end
        $display("run covered %0d samples and %0d result words in %0d closed runs",
                 samples_in, results_seen, closed_runs);
        $display("window length written %0d times, %0d mismatches", window_writes, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
